// ----- rtl/cfd_pkg.sv -----
// ----------------------------------------------------------------------------
// COBS frame decoder package
// Shared word types and constants of the COBS frame decoder.
// ----------------------------------------------------------------------------
package cfd_pkg;

  // A code byte of this value opens a group that is not followed by a zero.
  localparam logic [7:0] NoZeroCode = 8'hFF;

  // Register indexes of the configuration port.
  localparam logic RegMaxOutLen = 1'b0;

  localparam int unsigned LenWidth = 16;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       frame_start;
    logic       frame_last;
  } in_word_t;

  typedef struct packed {
    logic                has_byte;
    logic [7:0]          out_byte;
    logic                frame_end;
    logic [LenWidth-1:0] out_length;
  } out_word_t;

endpackage

// ----- rtl/cfd_regs.sv -----
// ----------------------------------------------------------------------------
// COBS frame decoder configuration registers
// APB-style register file holding the decoded length limit.
// ----------------------------------------------------------------------------
module cfd_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output logic [cfd_pkg::LenWidth-1:0] max_out_len_o
);

  logic [cfd_pkg::LenWidth-1:0] max_len_q, max_len_d;
  logic                         wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == cfd_pkg::RegMaxOutLen);

  always_comb begin
    max_len_d = max_len_q;
    if (wr_en) begin
      max_len_d = pwdata[cfd_pkg::LenWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= '1;
    end else begin
      max_len_q <= max_len_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == cfd_pkg::RegMaxOutLen) begin
      prdata = {{(32-cfd_pkg::LenWidth){1'b0}}, max_len_q};
    end
  end

  assign max_out_len_o = max_len_q;

endmodule

// ----- rtl/cfd_step.sv -----
// ----------------------------------------------------------------------------
// COBS frame decoder step
// Input register, decoder state and the per-byte decode logic.
// ----------------------------------------------------------------------------
module cfd_step (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  cfd_pkg::in_word_t            in_data_i,
  input  logic [cfd_pkg::LenWidth-1:0] max_out_len_i,
  input  logic                         room_i,
  output logic                         push_o,
  output cfd_pkg::out_word_t           result_o
);

  logic                         vld_q, vld_d;
  cfd_pkg::in_word_t            word_q;
  logic [7:0]                   group_q, group_d;
  logic [7:0]                   last_q, last_d;
  logic [cfd_pkg::LenWidth-1:0] count_q, count_d;
  logic                         stopped_q, stopped_d;

  logic                         fire;
  logic [7:0]                   eff_group, eff_last;
  logic [cfd_pkg::LenWidth-1:0] eff_count;
  logic                         eff_stopped;
  logic                         emit, frame_end;
  logic [7:0]                   value;

  assign fire       = vld_q && room_i;
  assign in_ready_o = !vld_q || room_i;

  always_comb begin
    vld_d = vld_q;
    if (in_ready_o) begin
      vld_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      word_q <= in_data_i;
    end
  end

  // A frame start clears the state before the word itself is decoded.
  always_comb begin
    eff_group   = word_q.frame_start ? 8'd0 : group_q;
    eff_last    = word_q.frame_start ? cfd_pkg::NoZeroCode : last_q;
    eff_count   = word_q.frame_start ? '0 : count_q;
    eff_stopped = word_q.frame_start ? 1'b0 : stopped_q;

    group_d   = eff_group;
    last_d    = eff_last;
    count_d   = eff_count;
    stopped_d = eff_stopped;
    emit      = 1'b0;
    frame_end = 1'b0;
    value     = 8'd0;

    if (!eff_stopped) begin
      if (eff_count >= max_out_len_i) begin
        frame_end = 1'b1;
      end else if (eff_group != 8'd0) begin
        emit    = 1'b1;
        value   = word_q.in_byte;
        group_d = eff_group - 8'd1;
      end else begin
        emit   = (eff_last != cfd_pkg::NoZeroCode);
        last_d = word_q.in_byte;
        if (word_q.in_byte == 8'd0) begin
          group_d   = 8'd0;
          frame_end = 1'b1;
        end else begin
          group_d = word_q.in_byte - 8'd1;
        end
      end

      // The count stays below the limit before an emit, so it cannot wrap.
      if (emit) begin
        count_d = eff_count + 1'b1;
        if (count_d >= max_out_len_i) begin
          frame_end = 1'b1;
        end
      end
      if (word_q.frame_last) begin
        frame_end = 1'b1;
      end
      if (frame_end) begin
        stopped_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q   <= 8'd0;
      last_q    <= cfd_pkg::NoZeroCode;
      count_q   <= '0;
      stopped_q <= 1'b0;
    end else if (fire) begin
      group_q   <= group_d;
      last_q    <= last_d;
      count_q   <= count_d;
      stopped_q <= stopped_d;
    end
  end

  assign push_o              = fire && (emit || frame_end);
  assign result_o.has_byte   = emit;
  assign result_o.out_byte   = value;
  assign result_o.frame_end  = frame_end;
  assign result_o.out_length = count_d;

  a_stopped_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && stopped_q && !word_q.frame_start) |-> !push_o)
    else $error("word decoded after the frame was closed");

  a_end_stops : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && result_o.frame_end) |=> stopped_q)
    else $error("frame end did not stop the decoder");

  a_restored_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !emit) |-> (value == 8'd0))
    else $error("data byte set without a decoded byte");

endmodule

// ----- rtl/cfd_out_buf.sv -----
// ----------------------------------------------------------------------------
// COBS frame decoder output buffer
// Two-word result register with skid slot, so decoding continues under stall.
// ----------------------------------------------------------------------------
module cfd_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  cfd_pkg::out_word_t push_data_i,
  output logic               room_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cfd_pkg::out_word_t out_data_o
);

  logic               head_vld_q, head_vld_d;
  logic               tail_vld_q, tail_vld_d;
  cfd_pkg::out_word_t head_q, head_d;
  cfd_pkg::out_word_t tail_q, tail_d;
  logic               pop;

  assign pop    = head_vld_q && out_ready_i;
  assign room_o = !tail_vld_q;

  always_comb begin
    head_vld_d = head_vld_q;
    tail_vld_d = tail_vld_q;
    head_d     = head_q;
    tail_d     = tail_q;
    if (pop) begin
      if (tail_vld_q) begin
        head_d     = tail_q;
        tail_vld_d = push_i;
        tail_d     = push_data_i;
      end else begin
        head_vld_d = push_i;
        head_d     = push_data_i;
      end
    end else if (push_i) begin
      if (!head_vld_q) begin
        head_vld_d = 1'b1;
        head_d     = push_data_i;
      end else begin
        tail_vld_d = 1'b1;
        tail_d     = push_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      tail_vld_q <= 1'b0;
    end else begin
      head_vld_q <= head_vld_d;
      tail_vld_q <= tail_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  assign out_valid_o = head_vld_q;
  assign out_data_o  = head_q;

  a_tail_behind_head : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_vld_q |-> head_vld_q)
    else $error("skid slot filled while the head is empty");

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && tail_vld_q) |-> pop)
    else $error("word pushed into a full buffer");

endmodule

// ----- rtl/cobs_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// COBS frame decoder
// Decodes a COBS-stuffed byte stream into data bytes and frame ends.
// ----------------------------------------------------------------------------
// The decoder takes one stuffed word per clock cycle while input ready is
// high and returns at most one result word for it. The word passes the input
// register, where the group countdown, code and length state are updated,
// and then the result register. A two-word result buffer lets the input
// side keep flowing while the consumer stalls; input ready drops
// only once both result slots are full. The first code byte of a frame, code
// bytes that open a group after a 0xFF code, and bytes arriving after the
// frame has closed produce no result word, unless the byte also closes the
// frame. The length limit is written through the register port at byte
// address 0 and should only be changed while the decoder is idle.
module cobs_frame_decoder (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  cfd_pkg::in_word_t      in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output cfd_pkg::out_word_t     out_data_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic [cfd_pkg::LenWidth-1:0] max_out_len;
  logic                         room;
  logic                         push;
  cfd_pkg::out_word_t           result;

  cfd_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .max_out_len_o (max_out_len)
  );

  cfd_step u_step (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_data_i     (in_data_i),
    .max_out_len_i (max_out_len),
    .room_i        (room),
    .push_o        (push),
    .result_o      (result)
  );

  cfd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (result),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- test/cobs_frame_decoder_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// COBS frame decoder testbench
// Drives stuffed words into the decoder and checks every result word against
// a cycle-free decoder predictor or a scripted word. A scripted part covers
// the corner cases, then random frames run under several length limits.
// ----------------------------------------------------------------------------
module cobs_frame_decoder_test;

  typedef logic [7:0] byte_q_t[$];
  typedef enum logic {StepWord, StepLimit} step_kind_e;
  typedef struct {
    step_kind_e          kind;
    cfd_pkg::in_word_t   word;
    logic [15:0]         limit;
    logic                typed;
    cfd_pkg::out_word_t  want;
  } script_step_t;

  localparam logic [2:0]         LimitAddr   = {cfd_pkg::RegMaxOutLen, 2'b00};
  localparam int                 CycleLimit  = 400000;
  localparam int                 DrainCycles = 8;
  localparam int                 NumSteps    = 31;
  localparam int                 NumPhases   = 7;
  localparam int                 PhaseWords  = 60;
  localparam int                 IdlePercent = 18;
  localparam cfd_pkg::out_word_t NoWant      = '0;

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  cfd_pkg::in_word_t  in_data_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  cfd_pkg::out_word_t out_data_o;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [2:0]         paddr       = '0;
  logic [31:0]        pwdata      = '0;
  logic [31:0]        prdata;
  logic               pready;

  // Predictor state, starting from the reset values.
  logic [7:0]  grp_left  = 8'h00;
  logic [7:0]  prev_code = cfd_pkg::NoZeroCode;
  logic [15:0] dec_count = 16'h0000;
  logic [15:0] len_limit = 16'hFFFF;
  logic        halted    = 1'b0;

  cfd_pkg::out_word_t expected_words[$];
  byte_q_t   held_tail;
  int        fails         = 0;
  int        words_sent    = 0;
  int        cycles        = 0;
  logic      calm          = 1'b0;

  script_step_t script [NumSteps] = '{
    '{StepWord,  '{8'h01, 1'b1, 1'b0}, 16'd0,     1'b0, NoWant},
    '{StepWord,  '{8'h03, 1'b0, 1'b0}, 16'd0,     1'b1, '{1'b1, 8'h00, 1'b0, 16'd1}},
    '{StepWord,  '{8'hFF, 1'b0, 1'b0}, 16'd0,     1'b1, '{1'b1, 8'hFF, 1'b0, 16'd2}},
    '{StepWord,  '{8'h00, 1'b0, 1'b0}, 16'd0,     1'b1, '{1'b1, 8'h00, 1'b0, 16'd3}},
    '{StepWord,  '{8'hFF, 1'b0, 1'b0}, 16'd0,     1'b1, '{1'b1, 8'h00, 1'b0, 16'd4}},
    '{StepWord,  '{8'h80, 1'b0, 1'b1}, 16'd0,     1'b1, '{1'b1, 8'h80, 1'b1, 16'd5}},
    '{StepWord,  '{8'h55, 1'b0, 1'b0}, 16'd0,     1'b0, NoWant},
    '{StepWord,  '{8'h42, 1'b0, 1'b1}, 16'd0,     1'b0, NoWant},
    '{StepWord,  '{8'h02, 1'b1, 1'b0}, 16'd0,     1'b0, NoWant},
    '{StepWord,  '{8'h11, 1'b0, 1'b0}, 16'd0,     1'b0, NoWant},
    '{StepWord,  '{8'h00, 1'b0, 1'b0}, 16'd0,     1'b1, '{1'b1, 8'h00, 1'b1, 16'd2}},
    '{StepWord,  '{8'h00, 1'b1, 1'b0}, 16'd0,     1'b1, '{1'b0, 8'h00, 1'b1, 16'd0}},
    '{StepWord,  '{8'h01, 1'b1, 1'b1}, 16'd0,     1'b1, '{1'b0, 8'h00, 1'b1, 16'd0}},
    '{StepLimit, '{8'h00, 1'b0, 1'b0}, 16'd0,     1'b0, NoWant},
    '{StepWord,  '{8'h05, 1'b1, 1'b0}, 16'd0,     1'b1, '{1'b0, 8'h00, 1'b1, 16'd0}},
    '{StepWord,  '{8'hFE, 1'b1, 1'b1}, 16'd0,     1'b1, '{1'b0, 8'h00, 1'b1, 16'd0}},
    '{StepLimit, '{8'h00, 1'b0, 1'b0}, 16'd2,     1'b0, NoWant},
    '{StepWord,  '{8'h04, 1'b1, 1'b0}, 16'd0,     1'b0, NoWant},
    '{StepWord,  '{8'hAA, 1'b0, 1'b0}, 16'd0,     1'b0, NoWant},
    '{StepWord,  '{8'hBB, 1'b0, 1'b0}, 16'd0,     1'b1, '{1'b1, 8'hBB, 1'b1, 16'd2}},
    '{StepWord,  '{8'hCC, 1'b0, 1'b0}, 16'd0,     1'b0, NoWant},
    '{StepWord,  '{8'h01, 1'b1, 1'b0}, 16'd0,     1'b0, NoWant},
    '{StepWord,  '{8'h01, 1'b0, 1'b0}, 16'd0,     1'b0, NoWant},
    '{StepWord,  '{8'h01, 1'b0, 1'b0}, 16'd0,     1'b1, '{1'b1, 8'h00, 1'b1, 16'd2}},
    '{StepLimit, '{8'h00, 1'b0, 1'b0}, 16'hFFFF,  1'b0, NoWant},
    '{StepWord,  '{8'h03, 1'b1, 1'b0}, 16'd0,     1'b0, NoWant},
    '{StepWord,  '{8'h7F, 1'b1, 1'b0}, 16'd0,     1'b0, NoWant},
    '{StepWord,  '{8'h01, 1'b0, 1'b0}, 16'd0,     1'b0, NoWant},
    '{StepWord,  '{8'h02, 1'b0, 1'b0}, 16'd0,     1'b0, NoWant},
    // The limit drops below the count while the frame is still open.
    '{StepLimit, '{8'h00, 1'b0, 1'b0}, 16'd1,     1'b0, NoWant},
    '{StepWord,  '{8'h03, 1'b0, 1'b0}, 16'd0,     1'b1, '{1'b0, 8'h00, 1'b1, 16'd2}}
  };

  cobs_frame_decoder uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("cobs_frame_decoder_test: done, errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= IdlePercent);
  end

  // Decodes one stuffed word and says whether the decoder should answer it.
  task automatic decode_model(input cfd_pkg::in_word_t word, output logic has_res,
                              output cfd_pkg::out_word_t res);
    logic       emit;
    logic       done;
    logic [7:0] value;
    emit    = 1'b0;
    done    = 1'b0;
    value   = 8'h00;
    has_res = 1'b0;
    res     = '0;
    if (word.frame_start) begin
      grp_left  = 8'h00;
      prev_code = cfd_pkg::NoZeroCode;
      dec_count = 16'h0000;
      halted    = 1'b0;
    end
    if (!halted) begin
      if (dec_count >= len_limit) begin
        done = 1'b1;
      end else if (grp_left != 8'h00) begin
        emit     = 1'b1;
        value    = word.in_byte;
        grp_left = grp_left - 8'd1;
      end else begin
        // A code word: the zero in front of it is restored unless the
        // previous group was a full one.
        if (prev_code != cfd_pkg::NoZeroCode) emit = 1'b1;
        prev_code = word.in_byte;
        if (word.in_byte == 8'h00) begin
          grp_left = 8'h00;
          done     = 1'b1;
        end else begin
          grp_left = word.in_byte - 8'd1;
        end
      end
      if (emit) begin
        dec_count = dec_count + 16'd1;
        if (dec_count >= len_limit) done = 1'b1;
      end
      if (word.frame_last) done = 1'b1;
      has_res = emit || done;
      res     = '{emit, value, done, dec_count};
      halted  = done;
    end
  endtask

  task automatic send_word(input cfd_pkg::in_word_t word, input logic typed = 1'b0,
                           input cfd_pkg::out_word_t want = '0);
    logic               has_res;
    cfd_pkg::out_word_t res;
    while (!calm && $urandom_range(99) < IdlePercent) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= word;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
    decode_model(word, has_res, res);
    if (typed) expected_words.push_back(want);
    else if (has_res) expected_words.push_back(res);
  endtask

  task automatic send_bytes(input byte_q_t enc, input logic with_start,
                            input logic with_last);
    cfd_pkg::in_word_t word;
    foreach (enc[i]) begin
      word.in_byte     = enc[i];
      word.frame_start = with_start && (i == 0);
      word.frame_last  = with_last && (i == enc.size() - 1);
      send_word(word);
    end
  endtask

  // The register may only change once every result word has come back and
  // any code word still in flight has had time to leave the pipeline.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_out_limit(input logic [15:0] value);
    logic [31:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LimitAddr;
    pwdata  <= {16'h0000, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    len_limit = value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback[15:0] !== value) begin
      $error("max_out_len: expected %0d, got %0d", value, readback[15:0]);
      fails++;
    end
  endtask

  function automatic byte_q_t stuff_frame(input byte_q_t payload);
    byte_q_t    enc;
    int         code_pos;
    logic [7:0] code;
    code_pos = 0;
    code     = 8'd1;
    enc.push_back(8'h00);
    foreach (payload[i]) begin
      if (payload[i] == 8'h00) begin
        enc[code_pos] = code;
        code_pos      = enc.size();
        enc.push_back(8'h00);
        code = 8'd1;
      end else begin
        enc.push_back(payload[i]);
        code = code + 8'd1;
        if (code == cfd_pkg::NoZeroCode) begin
          enc[code_pos] = code;
          code_pos      = enc.size();
          enc.push_back(8'h00);
          code = 8'd1;
        end
      end
    end
    enc[code_pos] = code;
    return enc;
  endfunction

  // Mostly short frames with plenty of zeros, now and then a long run that
  // needs full groups, and a few frames that are corrupted or left open.
  task automatic random_frame(output byte_q_t enc, output logic with_last);
    byte_q_t payload;
    int      len;
    int      zero_pct;
    int      pick;
    pick = $urandom_range(99);
    if (pick < 4) begin
      len      = $urandom_range(250, 300);
      zero_pct = 1;
    end else if (pick < 10) begin
      len      = 0;
      zero_pct = 0;
    end else begin
      len      = $urandom_range(1, 24);
      zero_pct = 25;
    end
    repeat (len) begin
      if ($urandom_range(99) < zero_pct) payload.push_back(8'h00);
      else payload.push_back(8'($urandom_range(1, 255)));
    end
    enc       = stuff_frame(payload);
    with_last = 1'b0;
    pick      = $urandom_range(99);
    if (pick < 75) enc.push_back(8'h00);
    else if (pick < 90) with_last = 1'b1;
    if ($urandom_range(99) < 8) enc[$urandom_range(enc.size() - 1)] = 8'($urandom);
  endtask

  initial begin
    cfd_pkg::in_word_t word;
    byte_q_t           enc;
    logic              with_last;
    logic [15:0]       limit;
    int                pick;
    int                cut;
    int                sent_start;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      if (script[i].kind == StepLimit) begin
        settle();
        set_out_limit(script[i].limit);
      end else begin
        send_word(script[i].word, script[i].typed, script[i].want);
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        1:       limit = 16'd0;
        2:       limit = 16'($urandom_range(2, 30));
        4:       limit = 16'd1;
        5:       limit = 16'($urandom);
        6:       limit = 16'd64;
        default: limit = 16'hFFFF;
      endcase
      settle();
      set_out_limit(limit);
      calm = (p == 3);
      sent_start = words_sent;
      // A frame left open at the end of the last phase carries on here,
      // under the new limit.
      if (held_tail.size() != 0) begin
        send_bytes(held_tail, 1'b0, 1'b0);
        held_tail.delete();
      end
      while (words_sent - sent_start < PhaseWords) begin
        pick = $urandom_range(99);
        if (pick < 10) begin
          repeat ($urandom_range(1, 12)) begin
            word.in_byte     = 8'($urandom);
            word.frame_start = $urandom_range(99) < 15;
            word.frame_last  = $urandom_range(99) < 10;
            send_word(word);
          end
        end else begin
          if (pick < 18) begin
            repeat ($urandom_range(1, 3)) begin
              word.in_byte     = 8'($urandom);
              word.frame_start = 1'b0;
              word.frame_last  = 1'($urandom_range(1));
              send_word(word);
            end
          end
          random_frame(enc, with_last);
          send_bytes(enc, 1'b1, with_last);
        end
      end
      if ($urandom_range(1) == 1) begin
        random_frame(enc, with_last);
        if (enc.size() >= 2) begin
          cut       = $urandom_range(1, enc.size() - 1);
          held_tail = enc[cut:$];
          enc       = enc[0:cut-1];
          send_bytes(enc, 1'b1, 1'b0);
        end
      end
      calm = 1'b0;
    end
    if (held_tail.size() != 0) send_bytes(held_tail, 1'b0, 1'b0);

    settle();
    if (fails == 0) begin
      $display("cobs_frame_decoder_test: done, clean");
    end else begin
      $display("cobs_frame_decoder_test: done, errors");
    end
    $finish;
  end

  always @(posedge clk_i) begin : check_results
    cfd_pkg::out_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_words.size() == 0) begin
        $error("result word %h arrived with none expected", out_data_o);
        fails++;
      end else begin
        want = expected_words.pop_front();
        if (out_data_o.has_byte !== want.has_byte) begin
          $error("has_byte: expected %0d, got %0d", want.has_byte, out_data_o.has_byte);
          fails++;
        end
        if (out_data_o.out_byte !== want.out_byte) begin
          $error("out_byte: expected %02h, got %02h", want.out_byte, out_data_o.out_byte);
          fails++;
        end
        if (out_data_o.frame_end !== want.frame_end) begin
          $error("frame_end: expected %0d, got %0d", want.frame_end, out_data_o.frame_end);
          fails++;
        end
        if (out_data_o.out_length !== want.out_length) begin
          $error("out_length: expected %0d, got %0d", want.out_length,
                 out_data_o.out_length);
          fails++;
        end
      end
    end
  end

endmodule

// ----- sim.f -----
rtl/cfd_pkg.sv
rtl/cfd_regs.sv
rtl/cfd_step.sv
rtl/cfd_out_buf.sv
rtl/cobs_frame_decoder.sv
test/cobs_frame_decoder_test.sv
